>>> src/rfes_pkg.sv
// Shared types and constants for the rocket flight event sequencer.
// No dependencies; every other file of the block uses this package, and all but rfes_if import it.
`timescale 1ns / 1ps
`default_nettype none

package rfes_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LAUNCH_ACCEL_THRESHOLD = 3'd0,
      CSR_SEP_DELAY_MS           = 3'd1,
      CSR_SEP_ALT_FLOOR          = 3'd2,
      CSR_EJ1_DELAY_MS           = 3'd3,
      CSR_EJ2_DELAY_MS           = 3'd4,
      CSR_EJ_ALT_FLOOR           = 3'd5
   } csr_index_type;

   localparam logic [14:0] RST_LAUNCH_ACCEL_THRESHOLD = 15'd2943;
   localparam logic [31:0] RST_SEP_DELAY_MS           = 32'd5000;
   localparam logic [23:0] RST_SEP_ALT_FLOOR          = 24'd0;
   localparam logic [31:0] RST_EJ1_DELAY_MS           = 32'd10000;
   localparam logic [31:0] RST_EJ2_DELAY_MS           = 32'd12000;
   localparam logic [23:0] RST_EJ_ALT_FLOOR           = 24'd0;
   localparam logic [29:0] RST_THRESHOLD_SQ =
      30'(32'(RST_LAUNCH_ACCEL_THRESHOLD) * 32'(RST_LAUNCH_ACCEL_THRESHOLD));

   localparam logic [1:0] PHASE_CODE_READY     = 2'd0;
   localparam logic [1:0] PHASE_CODE_BOOST     = 2'd1;
   localparam logic [1:0] PHASE_CODE_SEPARATED = 2'd2;

   localparam int STATUS_BIT_ALT  = 0;
   localparam int STATUS_BIT_TIME = 1;

   typedef enum logic [2:0] {
      PHASE_READY     = 3'b001,
      PHASE_BOOST     = 3'b010,
      PHASE_SEPARATED = 3'b100
   } phase_type;

   typedef struct packed {
      logic [14:0]        launch_accel_threshold;
      logic [31:0]        sep_delay_ms;
      logic signed [23:0] sep_alt_floor;
      logic [31:0]        ej1_delay_ms;
      logic [31:0]        ej2_delay_ms;
      logic signed [23:0] ej_alt_floor;
   } cfg_type;

   typedef struct packed {
      logic [31:0] time_now_ms;
      logic        accel_updated;
      logic        baro_updated;
      logic        launch_hit;
      logic        sep_alt_ok;
      logic        eject_alt_ok;
   } event_type;

   function automatic logic [1:0] phase_code(input phase_type phase);
      logic [1:0] code;
      case (phase)
         PHASE_READY:     code = PHASE_CODE_READY;
         PHASE_BOOST:     code = PHASE_CODE_BOOST;
         PHASE_SEPARATED: code = PHASE_CODE_SEPARATED;
         default:         code = PHASE_CODE_READY;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

>>> src/rfes_if.sv
// Channel interfaces of the sequencer: sample input, status result and register write.
// Depends on rfes_pkg for the register port widths.
`timescale 1ns / 1ps
`default_nettype none

interface rfes_req_if;
   logic               valid;
   logic               ready;
   logic [31:0]        time_now_ms;
   logic               accel_updated;
   logic               baro_updated;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   logic signed [23:0] altitude_cm;

   modport source (output valid, time_now_ms, accel_updated, baro_updated,
                   accel_x, accel_y, accel_z, altitude_cm, input ready);
   modport sink (input valid, time_now_ms, accel_updated, baro_updated,
                 accel_x, accel_y, accel_z, altitude_cm, output ready);
endinterface

interface rfes_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] flight_phase;
   logic       launched;
   logic       separated;
   logic       eject1_fired;
   logic       eject2_fired;
   logic [1:0] separation_status;
   logic [1:0] eject1_status;
   logic [1:0] eject2_status;

   modport source (output valid, flight_phase, launched, separated, eject1_fired,
                   eject2_fired, separation_status, eject1_status, eject2_status,
                   input ready);
   modport sink (input valid, flight_phase, launched, separated, eject1_fired,
                 eject2_fired, separation_status, eject1_status, eject2_status,
                 output ready);
endinterface

interface rfes_csr_if;
   logic                                valid;
   logic                                ready;
   logic [rfes_pkg::CSR_INDEX_W-1:0]    index;
   logic [rfes_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/rfes_front.sv
// Front end: accepts samples, squares the acceleration axes and classifies each sample.
// Depends on rfes_pkg and rfes_if; feeds rfes_queue.
`timescale 1ns / 1ps
`default_nettype none

module rfes_front (
   input  wire              clock,
   input  wire              reset,
   rfes_req_if.sink         req_ch,
   input  wire rfes_pkg::cfg_type cfg,
   output logic             push_valid,
   input  wire              push_ready,
   output rfes_pkg::event_type push_event
);
   import rfes_pkg::*;

   logic               stage_valid_ff, stage_valid_in;
   logic [30:0]        sq_x_ff, sq_y_ff, sq_z_ff;
   logic [31:0]        time_ff;
   logic               acc_upd_ff, baro_upd_ff, sep_alt_ok_ff, ej_alt_ok_ff;
   logic [29:0]        thr_sq_ff, thr_sq_in;
   logic signed [31:0] prod_x, prod_y, prod_z;
   logic [31:0]        mag_sq;
   logic               accept;

   assign req_ch.ready = !stage_valid_ff || push_ready;
   assign accept       = req_ch.valid && req_ch.ready;

   assign prod_x    = req_ch.accel_x * req_ch.accel_x;
   assign prod_y    = req_ch.accel_y * req_ch.accel_y;
   assign prod_z    = req_ch.accel_z * req_ch.accel_z;
   assign thr_sq_in = 30'(32'(cfg.launch_accel_threshold) * 32'(cfg.launch_accel_threshold));

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (push_ready) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         thr_sq_ff      <= RST_THRESHOLD_SQ;
      end else begin
         stage_valid_ff <= stage_valid_in;
         thr_sq_ff      <= thr_sq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sq_x_ff       <= 31'(unsigned'(prod_x));
         sq_y_ff       <= 31'(unsigned'(prod_y));
         sq_z_ff       <= 31'(unsigned'(prod_z));
         time_ff       <= req_ch.time_now_ms;
         acc_upd_ff    <= req_ch.accel_updated;
         baro_upd_ff   <= req_ch.baro_updated;
         sep_alt_ok_ff <= req_ch.altitude_cm >= cfg.sep_alt_floor;
         ej_alt_ok_ff  <= req_ch.altitude_cm >= cfg.ej_alt_floor;
      end
   end

   assign mag_sq = {1'b0, sq_x_ff} + {1'b0, sq_y_ff} + {1'b0, sq_z_ff};

   assign push_valid               = stage_valid_ff;
   assign push_event.time_now_ms   = time_ff;
   assign push_event.accel_updated = acc_upd_ff;
   assign push_event.baro_updated  = baro_upd_ff;
   assign push_event.launch_hit    = mag_sq >= {2'b00, thr_sq_ff};
   assign push_event.sep_alt_ok    = sep_alt_ok_ff;
   assign push_event.eject_alt_ok  = ej_alt_ok_ff;

endmodule

`default_nettype wire

>>> src/rfes_queue.sv
// Short first-in first-out queue of classified samples between front and back end.
// Depends on rfes_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module rfes_queue #(
   parameter int DEPTH = 2
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push_valid,
   output logic                push_ready,
   input  wire rfes_pkg::event_type push_event,
   output logic                pop_valid,
   input  wire                 pop_ready,
   output rfes_pkg::event_type pop_event
);
   import rfes_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   event_type       mem [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            push, pop;

   assign push_ready = count_ff != CW'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_event  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_event;
      end
   end

endmodule

`default_nettype wire

>>> src/rfes_back.sv
// Back end: flight phase state machine, launch time, sticky status and the result register.
// Depends on rfes_pkg and rfes_if; drains rfes_queue.
`timescale 1ns / 1ps
`default_nettype none

module rfes_back (
   input  wire                 clock,
   input  wire                 reset,
   input  wire rfes_pkg::cfg_type   cfg,
   input  wire                 pop_valid,
   output logic                pop_ready,
   input  wire rfes_pkg::event_type pop_event,
   rfes_rsp_if.source          rsp_ch
);
   import rfes_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [31:0] launch_time_ff, launch_time_in;
   logic        ej1_flag_ff, ej1_flag_in, ej2_flag_ff, ej2_flag_in;
   logic [1:0]  sep_bits_ff, sep_bits_in, ej1_bits_ff, ej1_bits_in;
   logic [1:0]  ej2_bits_ff, ej2_bits_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_phase_ff;
   logic [31:0] elapsed;
   logic        t_sep, t_ej1, t_ej2, alt_ej;
   logic        pop;

   assign pop_ready = !rsp_valid_ff || rsp_ch.ready;
   assign pop       = pop_valid && pop_ready;

   assign elapsed = pop_event.time_now_ms - launch_time_ff;
   assign t_sep   = elapsed > cfg.sep_delay_ms;
   assign t_ej1   = elapsed > cfg.ej1_delay_ms;
   assign t_ej2   = elapsed > cfg.ej2_delay_ms;
   assign alt_ej  = pop_event.eject_alt_ok;

   always_comb begin
      phase_in       = phase_ff;
      launch_time_in = launch_time_ff;
      ej1_flag_in    = ej1_flag_ff;
      ej2_flag_in    = ej2_flag_ff;
      sep_bits_in    = sep_bits_ff;
      ej1_bits_in    = ej1_bits_ff;
      ej2_bits_in    = ej2_bits_ff;
      case (phase_ff)
         PHASE_READY: begin
            if (pop_event.accel_updated && pop_event.launch_hit) begin
               phase_in       = PHASE_BOOST;
               launch_time_in = pop_event.time_now_ms;
            end
         end
         PHASE_BOOST: begin
            if (pop_event.baro_updated) begin
               sep_bits_in[STATUS_BIT_TIME] = sep_bits_ff[STATUS_BIT_TIME] | t_sep;
               sep_bits_in[STATUS_BIT_ALT]  = sep_bits_ff[STATUS_BIT_ALT] |
                                              pop_event.sep_alt_ok;
               if (&sep_bits_in) begin
                  phase_in = PHASE_SEPARATED;
               end
            end
         end
         PHASE_SEPARATED: begin
            if (pop_event.baro_updated) begin
               ej1_bits_in[STATUS_BIT_TIME] = ej1_bits_ff[STATUS_BIT_TIME] | t_ej1;
               ej1_bits_in[STATUS_BIT_ALT]  = ej1_bits_ff[STATUS_BIT_ALT] | alt_ej;
               ej1_flag_in = ej1_flag_ff | (t_ej1 & alt_ej);
               ej2_bits_in[STATUS_BIT_TIME] = ej2_bits_ff[STATUS_BIT_TIME] | t_ej2;
               ej2_bits_in[STATUS_BIT_ALT]  = ej2_bits_ff[STATUS_BIT_ALT] | alt_ej;
               ej2_flag_in = ej2_flag_ff | (&ej2_bits_in);
            end
         end
         default: begin
            phase_in = PHASE_READY;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PHASE_READY;
         launch_time_ff <= '0;
         ej1_flag_ff    <= 1'b0;
         ej2_flag_ff    <= 1'b0;
         sep_bits_ff    <= '0;
         ej1_bits_ff    <= '0;
         ej2_bits_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            phase_ff       <= phase_in;
            launch_time_ff <= launch_time_in;
            ej1_flag_ff    <= ej1_flag_in;
            ej2_flag_ff    <= ej2_flag_in;
            sep_bits_ff    <= sep_bits_in;
            ej1_bits_ff    <= ej1_bits_in;
            ej2_bits_ff    <= ej2_bits_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_phase_ff <= phase_code(phase_ff);
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.flight_phase      = rsp_phase_ff;
   assign rsp_ch.launched          = phase_ff != PHASE_READY;
   assign rsp_ch.separated         = phase_ff == PHASE_SEPARATED;
   assign rsp_ch.eject1_fired      = ej1_flag_ff;
   assign rsp_ch.eject2_fired      = ej2_flag_ff;
   assign rsp_ch.separation_status = sep_bits_ff;
   assign rsp_ch.eject1_status     = ej1_bits_ff;
   assign rsp_ch.eject2_status     = ej2_bits_ff;

endmodule

`default_nettype wire

>>> src/rocket_flight_event_sequencer_top.sv
// Top level of the rocket flight event sequencer: register file and the three pipeline parts.
// Depends on rfes_pkg, rfes_if, rfes_front, rfes_queue and rfes_back.
`timescale 1ns / 1ps
`default_nettype none

// The sequencer takes one sensor sample per clock cycle while the result side takes its results
// and returns exactly one status result per sample, in order. A sample is registered in the front
// end, where the acceleration axes are squared, then passes a small queue of QUEUE_DEPTH entries
// and is applied to the flight state in the back end, whose result register then shows it. The
// sustained rate of one sample per cycle is set by the single state update in the back end.
// Register writes are accepted in every cycle; write them only while no sample is in flight.
// A sample accepted in the cycle after a write already uses the new values. Writes to an
// unknown register index are ignored.

module rocket_flight_event_sequencer_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire       clock,
   input  wire       reset,
   rfes_req_if.sink  req_ch,
   rfes_rsp_if.source rsp_ch,
   rfes_csr_if.sink  csr_ch
);
   import rfes_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      push_valid, push_ready, pop_valid, pop_ready;
   event_type push_event, pop_event;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_LAUNCH_ACCEL_THRESHOLD: cfg_in.launch_accel_threshold = csr_ch.data[14:0];
            CSR_SEP_DELAY_MS:           cfg_in.sep_delay_ms           = csr_ch.data;
            CSR_SEP_ALT_FLOOR:          cfg_in.sep_alt_floor          = csr_ch.data[23:0];
            CSR_EJ1_DELAY_MS:           cfg_in.ej1_delay_ms           = csr_ch.data;
            CSR_EJ2_DELAY_MS:           cfg_in.ej2_delay_ms           = csr_ch.data;
            CSR_EJ_ALT_FLOOR:           cfg_in.ej_alt_floor           = csr_ch.data[23:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.launch_accel_threshold <= RST_LAUNCH_ACCEL_THRESHOLD;
         cfg_ff.sep_delay_ms           <= RST_SEP_DELAY_MS;
         cfg_ff.sep_alt_floor          <= RST_SEP_ALT_FLOOR;
         cfg_ff.ej1_delay_ms           <= RST_EJ1_DELAY_MS;
         cfg_ff.ej2_delay_ms           <= RST_EJ2_DELAY_MS;
         cfg_ff.ej_alt_floor           <= RST_EJ_ALT_FLOOR;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rfes_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .cfg        (cfg_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_event (push_event)
   );

   rfes_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_event (push_event),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_event  (pop_event)
   );

   rfes_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_event (pop_event),
      .rsp_ch    (rsp_ch)
   );

endmodule

`default_nettype wire

>>> src/rfes_checker.sv
// Port-level checks on the result channel of the sequencer, bound to the top level.
// Depends on rfes_pkg for the phase codes.
`timescale 1ns / 1ps
`default_nettype none

module rfes_checker (
   input wire       clock,
   input wire       reset,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire [1:0] flight_phase,
   input wire       launched,
   input wire       separated,
   input wire       eject1_fired,
   input wire [1:0] eject1_status
);
   import rfes_pkg::*;

   logic seen_launch_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_launch_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready && launched) begin
         seen_launch_ff <= 1'b1;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat withdrawn before it was taken");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_launch_ff |-> launched)
      else $error("launch indication dropped after it was reported");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && separated |-> launched &&
      (flight_phase == PHASE_CODE_BOOST || flight_phase == PHASE_CODE_SEPARATED))
      else $error("separation reported without a preceding launch");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && eject1_fired |-> separated && eject1_status == 2'b11)
      else $error("first ejection reported without its conditions");

endmodule

bind rocket_flight_event_sequencer_top rfes_checker u_rfes_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .flight_phase  (rsp_ch.flight_phase),
   .launched      (rsp_ch.launched),
   .separated     (rsp_ch.separated),
   .eject1_fired  (rsp_ch.eject1_fired),
   .eject1_status (rsp_ch.eject1_status)
);

`default_nettype wire

>>> tb/sv/rocket_flight_event_sequencer_top_tb.sv
// Self-checking testbench for the rocket flight event sequencer: drives sensor samples through
// one flight (ready, boost, separated), predicts every status beat and checks it in order.
// Depends on rfes_pkg, the rfes_if channel interfaces and rocket_flight_event_sequencer_top.
`timescale 1ns / 1ps

module rocket_flight_event_sequencer_top_tb;
   import rfes_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 4;
   localparam int REPORT_MAX   = 10;

   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_UNMAPPED_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_UNMAPPED_HI = 3'd7;

   localparam logic signed [23:0] ALT_MAX   = 24'sh7FFFFF;
   localparam logic signed [23:0] ALT_MIN   = 24'sh800000;
   localparam logic signed [15:0] AXIS_MAX  = 16'sh7FFF;
   localparam logic signed [15:0] AXIS_MIN  = 16'sh8000;
   localparam logic [31:0]        TIME_NEVER = 32'hFFFF_FFFF;

   typedef struct {
      logic [31:0]        time_now_ms;
      logic               accel_updated;
      logic               baro_updated;
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic signed [23:0] altitude_cm;
   } flight_sample_type;

   typedef struct packed {
      logic [1:0] flight_phase;
      logic       launched;
      logic       separated;
      logic       eject1_fired;
      logic       eject2_fired;
      logic [1:0] separation_status;
      logic [1:0] eject1_status;
      logic [1:0] eject2_status;
   } flight_status_type;

   logic clock;
   logic reset;

   rfes_req_if req_ch ();
   rfes_rsp_if rsp_ch ();
   rfes_csr_if csr_ch ();

   rocket_flight_event_sequencer_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   cfg_type        cfg;
   logic [1:0]     phase_now;
   logic [31:0]    launch_ms;
   logic           eject1_latched;
   logic           eject2_latched;
   logic [1:0]     sep_bits;
   logic [1:0]     ej1_bits;
   logic [1:0]     ej2_bits;

   flight_status_type pending_status[$];
   int             failures;
   int             cycle_count;
   bit             stall_on;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_on && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready = 1'b0;
            repeat ($urandom_range(1, 17) - 1) @(negedge clock);
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      flight_status_type got;
      flight_status_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got.flight_phase      = rsp_ch.flight_phase;
         got.launched          = rsp_ch.launched;
         got.separated         = rsp_ch.separated;
         got.eject1_fired      = rsp_ch.eject1_fired;
         got.eject2_fired      = rsp_ch.eject2_fired;
         got.separation_status = rsp_ch.separation_status;
         got.eject1_status     = rsp_ch.eject1_status;
         got.eject2_status     = rsp_ch.eject2_status;
         if (pending_status.size() == 0) begin
            failures++;
            if (failures <= REPORT_MAX)
               $display("Unexpected status beat at cycle %0d: %p", cycle_count, got);
         end else begin
            want = pending_status.pop_front();
            if (got.flight_phase !== want.flight_phase || got.launched !== want.launched ||
                got.separated !== want.separated || got.eject1_fired !== want.eject1_fired ||
                got.eject2_fired !== want.eject2_fired ||
                got.separation_status !== want.separation_status ||
                got.eject1_status !== want.eject1_status ||
                got.eject2_status !== want.eject2_status) begin
               failures++;
               if (failures <= REPORT_MAX)
                  $display("Status mismatch at cycle %0d: expected %p, actual %p",
                           cycle_count, want, got);
            end
         end
      end
   end

   function automatic flight_status_type advance_flight(input flight_sample_type s);
      flight_status_type st;
      logic [31:0]    elapsed;
      longint         mag_sq;
      longint         thr_sq;
      longint         alt;
      logic           eject1_time;
      logic           eject_alt;
      st.flight_phase = phase_now;
      elapsed = s.time_now_ms - launch_ms;
      alt = longint'(s.altitude_cm);
      case (phase_now)
         PHASE_CODE_READY: begin
            if (s.accel_updated) begin
               mag_sq = longint'(s.accel_x) * longint'(s.accel_x)
                      + longint'(s.accel_y) * longint'(s.accel_y)
                      + longint'(s.accel_z) * longint'(s.accel_z);
               thr_sq = longint'(cfg.launch_accel_threshold)
                      * longint'(cfg.launch_accel_threshold);
               if (mag_sq >= thr_sq) begin
                  phase_now = PHASE_CODE_BOOST;
                  launch_ms = s.time_now_ms;
               end
            end
         end
         PHASE_CODE_BOOST: begin
            if (s.baro_updated) begin
               if (elapsed > cfg.sep_delay_ms) sep_bits[STATUS_BIT_TIME] = 1'b1;
               if (alt >= longint'($signed(cfg.sep_alt_floor)))
                  sep_bits[STATUS_BIT_ALT] = 1'b1;
               if (sep_bits == 2'b11) phase_now = PHASE_CODE_SEPARATED;
            end
         end
         default: begin
            if (s.baro_updated) begin
               eject1_time = elapsed > cfg.ej1_delay_ms;
               eject_alt = alt >= longint'($signed(cfg.ej_alt_floor));
               if (eject1_time) ej1_bits[STATUS_BIT_TIME] = 1'b1;
               if (eject_alt) ej1_bits[STATUS_BIT_ALT] = 1'b1;
               if (eject1_time && eject_alt) eject1_latched = 1'b1;
               if (elapsed > cfg.ej2_delay_ms) ej2_bits[STATUS_BIT_TIME] = 1'b1;
               if (eject_alt) ej2_bits[STATUS_BIT_ALT] = 1'b1;
               if (ej2_bits == 2'b11) eject2_latched = 1'b1;
            end
         end
      endcase
      st.launched          = phase_now != PHASE_CODE_READY;
      st.separated         = phase_now == PHASE_CODE_SEPARATED;
      st.eject1_fired      = eject1_latched;
      st.eject2_fired      = eject2_latched;
      st.separation_status = sep_bits;
      st.eject1_status     = ej1_bits;
      st.eject2_status     = ej2_bits;
      return st;
   endfunction

   function automatic flight_sample_type make_sample(input logic [31:0] t, input bit acc,
         input bit baro, input logic signed [15:0] ax, input logic signed [15:0] ay,
         input logic signed [15:0] az, input logic signed [23:0] alt);
      flight_sample_type s;
      s.time_now_ms   = t;
      s.accel_updated = acc;
      s.baro_updated  = baro;
      s.accel_x       = ax;
      s.accel_y       = ay;
      s.accel_z       = az;
      s.altitude_cm   = alt;
      return s;
   endfunction

   // Half of the samples fall within span_ms after near_ms, the rest anywhere on the 32-bit clock.
   function automatic flight_sample_type random_sample(input logic [31:0] near_ms,
         input int unsigned span_ms, input logic signed [23:0] alt_hot);
      flight_sample_type s;
      s.time_now_ms   = $urandom_range(0, 1) ? near_ms + $urandom_range(0, span_ms)
                                             : $urandom();
      s.accel_updated = $urandom_range(0, 1);
      s.baro_updated  = $urandom_range(0, 3) != 0;
      s.accel_x       = 16'($urandom());
      s.accel_y       = 16'($urandom());
      s.accel_z       = 16'($urandom());
      s.altitude_cm   = ($urandom_range(0, 9) == 0) ? alt_hot : 24'($urandom());
      return s;
   endfunction

   task automatic send_sample(input flight_sample_type s);
      @(negedge clock);
      if (stall_on && $urandom_range(0, 5) == 0) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_ch.valid         = 1'b1;
      req_ch.time_now_ms   = s.time_now_ms;
      req_ch.accel_updated = s.accel_updated;
      req_ch.baro_updated  = s.baro_updated;
      req_ch.accel_x       = s.accel_x;
      req_ch.accel_y       = s.accel_y;
      req_ch.accel_z       = s.accel_z;
      req_ch.altitude_cm   = s.altitude_cm;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      pending_status.push_back(advance_flight(s));
   endtask

   task automatic drain_status();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index, input logic [31:0] value);
      logic [31:0] word;
      word = value;
      case (index)
         CSR_LAUNCH_ACCEL_THRESHOLD:              word[31:15] = 17'($urandom());
         CSR_SEP_ALT_FLOOR, CSR_EJ_ALT_FLOOR:     word[31:24] = 8'($urandom());
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid = 1'b1;
      csr_ch.index = index;
      csr_ch.data  = word;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      case (index)
         CSR_LAUNCH_ACCEL_THRESHOLD: cfg.launch_accel_threshold = word[14:0];
         CSR_SEP_DELAY_MS:           cfg.sep_delay_ms           = word;
         CSR_SEP_ALT_FLOOR:          cfg.sep_alt_floor          = word[23:0];
         CSR_EJ1_DELAY_MS:           cfg.ej1_delay_ms           = word;
         CSR_EJ2_DELAY_MS:           cfg.ej2_delay_ms           = word;
         CSR_EJ_ALT_FLOOR:           cfg.ej_alt_floor           = word[23:0];
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic test_ready_unused_flags();
      send_sample(make_sample(32'd0, 1'b0, 1'b1, 16'sd0, 16'sd0, 16'sd0, ALT_MAX));
      send_sample(make_sample(TIME_NEVER, 1'b0, 1'b0, AXIS_MIN, AXIS_MIN, AXIS_MIN, ALT_MIN));
      send_sample(make_sample(32'd17, 1'b1, 1'b0, 16'sd2942, 16'sd0, 16'sd0, 24'sd0));
      send_sample(make_sample(32'd18, 1'b1, 1'b1, 16'sd0, 16'sd0, -16'sd2942, 24'sd0));
   endtask

   task automatic test_launch_threshold_max();
      flight_sample_type s;
      drain_status();
      write_register(CSR_LAUNCH_ACCEL_THRESHOLD, 32'd32767);
      write_register(CSR_INDEX_UNMAPPED_LO, $urandom());
      write_register(CSR_INDEX_UNMAPPED_HI, $urandom());
      send_sample(make_sample(32'd40, 1'b1, 1'b1, AXIS_MAX - 16'sd1, 16'sd0, 16'sd0, 24'sd0));
      // Fresh readings are halved so their squared sum stays below the maximum threshold.
      for (int i = 0; i < 120; i++) begin
         s = random_sample(32'd0, 20000, ALT_MAX);
         if (s.accel_updated) begin
            s.accel_x = s.accel_x >>> 1;
            s.accel_y = s.accel_y >>> 1;
            s.accel_z = s.accel_z >>> 1;
         end
         stall_on = (i % 60) >= 15;
         send_sample(s);
      end
   endtask

   task automatic test_launch_at_zero_threshold();
      drain_status();
      write_register(CSR_LAUNCH_ACCEL_THRESHOLD, 32'd0);
      send_sample(make_sample(32'hFFFF_FF00, 1'b0, 1'b1, AXIS_MAX, AXIS_MAX, AXIS_MAX, 24'sd0));
      send_sample(make_sample(32'hFFFF_FF00, 1'b1, 1'b0, 16'sd0, 16'sd0, 16'sd0, 24'sd0));
   endtask

   task automatic test_boost_huge_timeout();
      drain_status();
      write_register(CSR_SEP_ALT_FLOOR, 32'(ALT_MAX));
      write_register(CSR_SEP_DELAY_MS, TIME_NEVER);
      send_sample(make_sample(launch_ms + 32'd5, 1'b1, 1'b0, AXIS_MIN, AXIS_MAX, AXIS_MIN,
                              ALT_MAX));
      send_sample(make_sample(launch_ms - 32'd1, 1'b0, 1'b1, 16'sd0, 16'sd0, 16'sd0,
                              ALT_MAX - 24'sd1));
      for (int i = 0; i < 120; i++) begin
         stall_on = (i % 60) < 45;
         send_sample(random_sample(launch_ms, 20000, ALT_MAX));
      end
   endtask

   task automatic test_separation_time_wrap();
      drain_status();
      write_register(CSR_SEP_DELAY_MS, 32'd100);
      write_register(CSR_SEP_ALT_FLOOR, 32'(ALT_MIN));
      send_sample(make_sample(launch_ms + 32'd100, 1'b0, 1'b1, 16'sd0, 16'sd0, 16'sd0,
                              ALT_MIN));
      send_sample(make_sample(launch_ms + 32'h110, 1'b0, 1'b1, 16'sd0, 16'sd0, 16'sd0,
                              ALT_MIN));
   endtask

   task automatic test_eject_altitude_gate();
      drain_status();
      write_register(CSR_EJ_ALT_FLOOR, 32'(ALT_MAX));
      write_register(CSR_EJ1_DELAY_MS, TIME_NEVER);
      write_register(CSR_EJ2_DELAY_MS, 32'd1000);
      send_sample(make_sample(launch_ms + 32'd5000, 1'b1, 1'b0, AXIS_MAX, 16'sd0, 16'sd0,
                              ALT_MAX));
      send_sample(make_sample(launch_ms + 32'd1000, 1'b0, 1'b1, 16'sd0, 16'sd0, 16'sd0,
                              ALT_MAX - 24'sd1));
      for (int i = 0; i < 100; i++) begin
         stall_on = (i % 50) >= 10;
         send_sample(random_sample(launch_ms, 20000, ALT_MAX));
      end
   endtask

   task automatic test_eject1_same_sample();
      drain_status();
      write_register(CSR_EJ1_DELAY_MS, 32'd0);
      send_sample(make_sample(launch_ms, 1'b0, 1'b1, 16'sd0, 16'sd0, 16'sd0, ALT_MAX));
      send_sample(make_sample(launch_ms + 32'd1, 1'b0, 1'b1, 16'sd0, 16'sd0, 16'sd0,
                              ALT_MAX - 24'sd1));
      send_sample(make_sample(launch_ms + 32'd2, 1'b0, 1'b1, 16'sd0, 16'sd0, 16'sd0, ALT_MAX));
      send_sample(make_sample(launch_ms + 32'd3, 1'b0, 1'b1, 16'sd0, 16'sd0, 16'sd0, ALT_MAX));
   endtask

   task automatic test_repeated_ejections();
      for (int round = 0; round < 3; round++) begin
         drain_status();
         write_register(CSR_EJ1_DELAY_MS,
                        round == 0 ? 32'($urandom_range(0, 30000)) :
                        round == 1 ? TIME_NEVER : $urandom());
         write_register(CSR_EJ2_DELAY_MS,
                        round == 0 ? 32'd0 : 32'($urandom_range(0, 40000)));
         write_register(CSR_EJ_ALT_FLOOR, round == 0 ? 32'(ALT_MIN) : $urandom());
         stall_on = round != 2;
         for (int i = 0; i < 50; i++)
            send_sample(random_sample(launch_ms, 40000, cfg.ej_alt_floor));
      end
   endtask

   initial begin
      reset                = 1'b1;
      stall_on             = 1'b0;
      failures             = 0;
      cycle_count          = 0;
      req_ch.valid         = 1'b0;
      req_ch.time_now_ms   = '0;
      req_ch.accel_updated = 1'b0;
      req_ch.baro_updated  = 1'b0;
      req_ch.accel_x       = '0;
      req_ch.accel_y       = '0;
      req_ch.accel_z       = '0;
      req_ch.altitude_cm   = '0;
      csr_ch.valid         = 1'b0;
      csr_ch.index         = '0;
      csr_ch.data          = '0;
      cfg.launch_accel_threshold = RST_LAUNCH_ACCEL_THRESHOLD;
      cfg.sep_delay_ms           = RST_SEP_DELAY_MS;
      cfg.sep_alt_floor          = RST_SEP_ALT_FLOOR;
      cfg.ej1_delay_ms           = RST_EJ1_DELAY_MS;
      cfg.ej2_delay_ms           = RST_EJ2_DELAY_MS;
      cfg.ej_alt_floor           = RST_EJ_ALT_FLOOR;
      phase_now      = PHASE_CODE_READY;
      launch_ms      = '0;
      eject1_latched = 1'b0;
      eject2_latched = 1'b0;
      sep_bits       = '0;
      ej1_bits       = '0;
      ej2_bits       = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      test_ready_unused_flags();
      test_launch_threshold_max();
      test_launch_at_zero_threshold();
      test_boost_huge_timeout();
      test_separation_time_wrap();
      test_eject_altitude_gate();
      test_eject1_same_sample();
      test_repeated_ejections();

      drain_status();
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/rfes_pkg.sv
src/rfes_if.sv
src/rfes_front.sv
src/rfes_queue.sv
src/rfes_back.sv
src/rocket_flight_event_sequencer_top.sv
src/rfes_checker.sv
tb/sv/rocket_flight_event_sequencer_top_tb.sv
